// ===== rtl/mts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, codes and types for the min tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int COUNT_OUT_W = 7;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_code_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic exec;
      logic finish;
   } cmd_type;

endpackage

// ===== rtl/mts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_ctrl
// Request sequencer: execute on accept, then settle the top and respond.
// ----------------------------------------------------------------------------
module mts_ctrl
   import mts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output logic    rsp_valid,
   output cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.exec   = start && (state_ff == ST_IDLE);
   assign cmd.finish = (state_ff == ST_FETCH);

endmodule

// ===== rtl/mts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_datapath
// Entry memory, fill count and cached top entry with its running minimum.
// ----------------------------------------------------------------------------
module mts_datapath
   import mts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic                      req_op,
   input  logic signed [DATA_W-1:0]  req_push_value,
   output logic signed [DATA_W-1:0]  rsp_top_value,
   output logic signed [DATA_W-1:0]  rsp_current_min,
   output logic [COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic                      rsp_is_empty,
   output logic [1:0]                rsp_status
);

   // each entry holds {value, minimum at or below it}
   logic [2*DATA_W-1:0]       mem [STACK_DEPTH];
   logic [2*DATA_W-1:0]       rd_data_ff;

   logic [CNT_W-1:0]          count_ff;
   logic signed [DATA_W-1:0]  top_val_ff;
   logic signed [DATA_W-1:0]  top_min_ff;
   logic                      load_ff;
   status_code_type           status_ff;

   logic                      is_full;
   logic                      is_empty;
   logic signed [DATA_W-1:0]  new_min;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr;

   assign is_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_empty = (count_ff == '0);
   assign new_min  = (!is_empty && (top_min_ff < req_push_value)) ? top_min_ff
                                                                  : req_push_value;
   assign wr_addr  = count_ff[ADDR_W-1:0];
   // new top after a pop sits two below the current count
   assign rd_addr  = ADDR_W'(count_ff - CNT_W'(2));

   always_ff @(posedge clock) begin
      if (cmd.exec && (req_op == OP_PUSH) && !is_full) begin
         mem[wr_addr] <= {req_push_value, new_min};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         load_ff   <= 1'b0;
         status_ff <= STATUS_OK;
      end else if (cmd.exec) begin
         load_ff   <= 1'b0;
         status_ff <= STATUS_OK;
         if (req_op == OP_PUSH) begin
            if (is_full) begin
               status_ff <= STATUS_OVERFLOW;
            end else begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end else begin
            if (is_empty) begin
               status_ff <= STATUS_UNDERFLOW;
            end else begin
               count_ff <= count_ff - CNT_W'(1);
               load_ff  <= (count_ff > CNT_W'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && (req_op == OP_PUSH) && !is_full) begin
         top_val_ff <= req_push_value;
         top_min_ff <= new_min;
      end else if (cmd.finish && load_ff) begin
         top_val_ff <= rd_data_ff[2*DATA_W-1:DATA_W];
         top_min_ff <= rd_data_ff[DATA_W-1:0];
      end
   end

   assign rsp_top_value   = is_empty ? '0 : top_val_ff;
   assign rsp_current_min = is_empty ? '0 : top_min_ff;
   assign rsp_entry_count = COUNT_OUT_W'(count_ff);
   assign rsp_is_empty    = is_empty;
   assign rsp_status      = status_ff;

endmodule

// ===== rtl/min_tracking_stack_top.sv =====
`timescale 1ns / 1ps
// response: the strobe is registered from the fetch state, not from the accepting edge
// a new request is not taken while busy; a pop fetches the new top from the
//   entry memory, whose read data is registered
// busy is high for the one cycle between accept and response; start is taken
//   again in the response cycle
// reset: synchronous, empties the stack; entry memory is not cleared
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// Bounded lifo of signed values that reports the running minimum.
// ----------------------------------------------------------------------------
module min_tracking_stack_top
   import mts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic signed [DATA_W-1:0]  req_push_value,
   output logic                      rsp_valid,
   output logic signed [DATA_W-1:0]  rsp_top_value,
   output logic signed [DATA_W-1:0]  rsp_current_min,
   output logic [COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic                      rsp_is_empty,
   output logic [1:0]                rsp_status
);

   cmd_type cmd;

   mts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   mts_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_op),
      .req_push_value  (req_push_value),
      .rsp_top_value   (rsp_top_value),
      .rsp_current_min (rsp_current_min),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

`ifndef NO_ASSERTIONS
   a_accept_then_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not enter the fetch cycle");

   a_busy_then_rsp : assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("fetch cycle not followed by a response");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_OVERFLOW))
         |-> (rsp_entry_count == COUNT_OUT_W'(STACK_DEPTH)))
      else $error("overflow reported on a stack that is not full");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and directed push/pop requests into the min tracking stack
// and checks every response against a running model of the stack contents.
// ----------------------------------------------------------------------------
module testbench;
   import mts_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REQUEST_TARGET = 1550;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] current_min;
      logic [COUNT_OUT_W-1:0]   entry_count;
      logic                     is_empty;
      status_code_type          status;
   } stack_view_type;

   class min_stack_scoreboard;
      logic signed [DATA_W-1:0] value_copy [STACK_DEPTH];
      logic signed [DATA_W-1:0] min_copy [STACK_DEPTH];
      int                       fill;
      stack_view_type           expected_views [$];
      int                       mismatches;
      int                       failures;

      function new();
         fill       = 0;
         mismatches = 0;
         failures   = 0;
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      function void note_request(logic op, logic signed [DATA_W-1:0] value);
         stack_view_type  view;
         status_code_type code;
         code = STATUS_OK;
         if (op == OP_PUSH) begin
            if (fill >= STACK_DEPTH) begin
               code = STATUS_OVERFLOW;
            end else begin
               value_copy[fill] = value;
               if (fill > 0 && min_copy[fill-1] < value) begin
                  min_copy[fill] = min_copy[fill-1];
               end else begin
                  min_copy[fill] = value;
               end
               fill++;
            end
         end else if (fill == 0) begin
            code = STATUS_UNDERFLOW;
         end else begin
            fill--;
         end
         view.top_value   = (fill > 0) ? value_copy[fill-1] : '0;
         view.current_min = (fill > 0) ? min_copy[fill-1] : '0;
         view.entry_count = fill[COUNT_OUT_W-1:0];
         view.is_empty    = (fill == 0);
         view.status      = code;
         expected_views.push_back(view);
      endfunction

      function void check_result(stack_view_type got);
         stack_view_type want;
         if (expected_views.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with no request pending: top %0d min %0d count %0d",
                        $realtime, got.top_value, got.current_min, got.entry_count);
            return;
         end
         want = expected_views.pop_front();
         if (got.top_value !== want.top_value || got.current_min !== want.current_min ||
             got.entry_count !== want.entry_count || got.is_empty !== want.is_empty ||
             got.status !== want.status) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response mismatch", $realtime);
               $display("   expected top %0d min %0d count %0d empty %0b status %0d",
                        want.top_value, want.current_min, want.entry_count,
                        want.is_empty, want.status);
               $display("   actual   top %0d min %0d count %0d empty %0b status %0d",
                        got.top_value, got.current_min, got.entry_count,
                        got.is_empty, got.status);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_op;
   logic signed [DATA_W-1:0] req_push_value;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_top_value;
   logic signed [DATA_W-1:0] rsp_current_min;
   logic [COUNT_OUT_W-1:0]   rsp_entry_count;
   logic                     rsp_is_empty;
   logic [1:0]               rsp_status;

   min_stack_scoreboard stack_board = new();
   int                  idle_cycles = 0;
   int                  requests_sent = 0;
   int                  burst_left = 0;
   int                  level = 0;

   min_tracking_stack_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_top_value   (rsp_top_value),
      .rsp_current_min (rsp_current_min),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // requests are noted before responses so a same-edge pair stays in order
   always @(posedge clock) begin
      stack_view_type got;
      if (!reset) begin
         if (start && !busy)
            stack_board.note_request(req_op, req_push_value);
         if (rsp_valid) begin
            got.top_value   = rsp_top_value;
            got.current_min = rsp_current_min;
            got.entry_count = rsp_entry_count;
            got.is_empty    = rsp_is_empty;
            got.status      = status_code_type'(rsp_status);
            stack_board.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic send_request(input logic op, input logic signed [DATA_W-1:0] value);
      start          <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      do @(posedge clock); while (busy);
      if (op == OP_PUSH && level < STACK_DEPTH)
         level++;
      else if (op == OP_POP && level > 0)
         level--;
   endtask

   task automatic hold_off(input int cycles);
      start          <= 1'b0;
      req_op         <= 1'($urandom);
      req_push_value <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // sender works in bursts; a random gap between bursts shifts the phase
   task automatic issue(input logic op, input logic signed [DATA_W-1:0] value);
      send_request(op, value);
      requests_sent++;
      if (burst_left == 0) begin
         hold_off($urandom_range(1, 7));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 5))
               0: return 32'sh8000_0000;
               1: return 32'sh7fff_ffff;
               2: return 32'sh8000_0001;
               3: return 32'sh7fff_fffe;
               4: return -32'sd1;
               default: return 32'sd0;
            endcase
         end
         1: return $signed($urandom_range(0, 16)) - 32'sd8;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_segment();
      int length;
      int pick;
      pick = $urandom_range(0, 4);
      case (pick)
         // fill to the top and push past it
         0: begin
            length = STACK_DEPTH - level + $urandom_range(1, 4);
            repeat (length) issue(OP_PUSH, pick_value());
         end
         // drain to empty and pop past it
         1: begin
            length = level + $urandom_range(1, 3);
            repeat (length) issue(OP_POP, pick_value());
         end
         default: begin
            length = $urandom_range(10, 60);
            repeat (length)
               issue(($urandom_range(0, 99) < 40 + 10 * pick) ? OP_PUSH : OP_POP,
                     pick_value());
         end
      endcase
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = OP_PUSH;
      req_push_value = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: underflow, extremes, equal minimum, drain past empty
      burst_left = 30;
      send_request(OP_POP, 32'sd7);
      send_request(OP_PUSH, 32'sh7fff_ffff);
      send_request(OP_PUSH, 32'sh8000_0000);
      send_request(OP_PUSH, 32'sh8000_0000);
      send_request(OP_PUSH, 32'sd5);
      send_request(OP_PUSH, -32'sd1);
      send_request(OP_PUSH, 32'sh7fff_ffff);
      repeat (6) send_request(OP_POP, 32'sh5555_aaaa);
      send_request(OP_POP, '0);
      send_request(OP_PUSH, -32'sd1);
      send_request(OP_PUSH, -32'sd1);
      send_request(OP_PUSH, 32'sd0);
      send_request(OP_PUSH, -32'sd2);
      repeat (5) send_request(OP_POP, '0);
      requests_sent = 23;
      burst_left    = 0;

      while (requests_sent < REQUEST_TARGET)
         run_segment();
      start <= 1'b0;

      while (stack_board.pending() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (stack_board.failures == 0 && stack_board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
